// ===== src/lcsp_pkg.sv =====
package lcsp_pkg;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_T  = 8'h54;
    localparam logic [7:0] CH_UC_L  = 8'h4C;
    localparam logic [7:0] CH_UC_S  = 8'h53;

    // record kinds
    localparam logic [1:0] REC_NUMBER = 2'd0;
    localparam logic [1:0] REC_OK     = 2'd1;
    localparam logic [1:0] REC_BAD    = 2'd2;

    // level kinds
    localparam logic [1:0] LVL_TASK = 2'd0;
    localparam logic [1:0] LVL_LOOP = 2'd1;
    localparam logic [1:0] LVL_ITER = 2'd2;

    // template lengths
    localparam logic [4:0] TR_LEN  = 5'd25;
    localparam logic [4:0] LP_LEN  = 5'd19;
    localparam logic [4:0] SEQ_LEN = 5'd17;

    // queue entry between front and back
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
        logic       is_digit;
        logic [3:0] digit;
    } q_entry_t;

    // TaskRegion(No(#),Task(%))
    function automatic logic [7:0] tr_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "T";
            5'd1:    c = "a";
            5'd2:    c = "s";
            5'd3:    c = "k";
            5'd4:    c = "R";
            5'd5:    c = "e";
            5'd6:    c = "g";
            5'd7:    c = "i";
            5'd8:    c = "o";
            5'd9:    c = "n";
            5'd10:   c = "(";
            5'd11:   c = "N";
            5'd12:   c = "o";
            5'd13:   c = "(";
            5'd14:   c = "#";
            5'd15:   c = ")";
            5'd16:   c = ",";
            5'd17:   c = "T";
            5'd18:   c = "a";
            5'd19:   c = "s";
            5'd20:   c = "k";
            5'd21:   c = "(";
            5'd22:   c = "%";
            5'd23:   c = ")";
            5'd24:   c = ")";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Loop(No(#),Iter(%))
    function automatic logic [7:0] lp_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "L";
            5'd1:    c = "o";
            5'd2:    c = "o";
            5'd3:    c = "p";
            5'd4:    c = "(";
            5'd5:    c = "N";
            5'd6:    c = "o";
            5'd7:    c = "(";
            5'd8:    c = "#";
            5'd9:    c = ")";
            5'd10:   c = ",";
            5'd11:   c = "I";
            5'd12:   c = "t";
            5'd13:   c = "e";
            5'd14:   c = "r";
            5'd15:   c = "(";
            5'd16:   c = "%";
            5'd17:   c = ")";
            5'd18:   c = ")";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // sequential-branch marker with its space removed
    function automatic logic [7:0] seq_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "S";
            5'd1:    c = "e";
            5'd2:    c = "q";
            5'd3:    c = "u";
            5'd4:    c = "e";
            5'd5:    c = "n";
            5'd6:    c = "t";
            5'd7:    c = "i";
            5'd8:    c = "a";
            5'd9:    c = "l";
            5'd10:   c = "b";
            5'd11:   c = "r";
            5'd12:   c = "a";
            5'd13:   c = "n";
            5'd14:   c = "c";
            5'd15:   c = "h";
            5'd16:   c = ".";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] tmpl_char(input logic level, input logic [4:0] idx);
        return level ? lp_char(idx) : tr_char(idx);
    endfunction

endpackage

// ===== src/lcsp_char_if.sv =====
interface lcsp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== src/lcsp_rec_if.sv =====
interface lcsp_rec_if #(
    parameter int NUMBER_BITS = 31
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             record_kind;
    logic [1:0]             level_kind;
    logic [NUMBER_BITS-1:0] number_value;
    logic                   last_of_level;

    modport source (output valid, output record_kind, output level_kind,
                    output number_value, output last_of_level, input ready);
    modport sink (input valid, input record_kind, input level_kind,
                  input number_value, input last_of_level, output ready);
endinterface

// ===== src/lcsp_front.sv =====
module lcsp_front (
    lcsp_char_if.sink         chars,
    input  logic              q_ready,
    output logic              push,
    output lcsp_pkg::q_entry_t push_entry
);
    logic is_ws;
    logic keep;

    assign is_ws = (chars.char_code == lcsp_pkg::CH_SPACE) ||
                   (chars.char_code == lcsp_pkg::CH_TAB)   ||
                   (chars.char_code == lcsp_pkg::CH_NL)    ||
                   (chars.char_code == lcsp_pkg::CH_QUOTE);

    // end of text always goes through; blanks are dropped here
    assign keep = chars.end_of_text || !is_ws;

    assign chars.ready = q_ready;
    assign push        = chars.valid && q_ready && keep;

    always_comb
    begin
        push_entry.char_code   = chars.char_code;
        push_entry.end_of_text = chars.end_of_text;
        push_entry.is_digit    = (chars.char_code >= lcsp_pkg::CH_ZERO) &&
                                 (chars.char_code <= lcsp_pkg::CH_NINE);
        push_entry.digit       = 4'(chars.char_code - lcsp_pkg::CH_ZERO);
    end
endmodule

// ===== src/lcsp_queue.sv =====
module lcsp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lcsp_pkg::q_entry_t push_entry,
    output logic               q_ready,
    input  logic               pop,
    output logic               q_valid,
    output lcsp_pkg::q_entry_t q_entry
);
    lcsp_pkg::q_entry_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(do_pop);
        end
    end
endmodule

// ===== src/lcsp_back.sv =====
module lcsp_back #(
    parameter int NUMBER_BITS = 31
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  lcsp_pkg::q_entry_t q_entry,
    output logic               pop,
    lcsp_rec_if.source         records
);
    typedef enum logic [1:0] {
        PH_START,
        PH_AFTER_LEVEL,
        PH_AFTER_COMMA,
        PH_IN_LEVEL
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [4:0]             kidx_reg, kidx_next;
    logic                   level_reg, level_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   digits_reg, digits_next;
    logic                   err_reg, err_next;
    logic                   term_reg, term_next;
    logic                   seq_reg, seq_next;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             kind_reg, kind_next;
    logic [1:0]             lvl_reg, lvl_next;
    logic [NUMBER_BITS-1:0] num_reg, num_next;
    logic                   last_reg, last_next;

    logic                   emit;
    logic                   eot_ok;
    logic [4:0]             tmpl_len;
    logic [4:0]             kidx_inc;
    logic [7:0]             tc;
    logic [7:0]             tc_inc;
    logic                   is_slot;
    logic                   is_list;
    logic                   comma_ok;
    logic [7:0]             c;
    logic [NUMBER_BITS+3:0] acc_ext;
    logic [NUMBER_BITS+3:0] acc_wide;
    logic [NUMBER_BITS-1:0] acc_sat;

    assign pop = q_valid && (!out_valid_reg || records.ready);
    assign c   = q_entry.char_code;

    assign tmpl_len = level_reg ? lcsp_pkg::LP_LEN : lcsp_pkg::TR_LEN;
    assign kidx_inc = kidx_reg + 5'd1;
    assign tc       = lcsp_pkg::tmpl_char(level_reg, kidx_reg);
    assign tc_inc   = lcsp_pkg::tmpl_char(level_reg, kidx_inc);
    assign is_slot  = (tc == lcsp_pkg::CH_HASH) || (tc == lcsp_pkg::CH_PCT);
    assign is_list  = (tc == lcsp_pkg::CH_PCT);
    assign comma_ok = (phase_reg != PH_AFTER_COMMA);

    // acc*10 + d by shift-add; overflow past the field width saturates
    assign acc_ext  = {4'b0000, acc_reg};
    assign acc_wide = (acc_ext << 3) + (acc_ext << 1) +
                      {{NUMBER_BITS{1'b0}}, q_entry.digit};
    assign acc_sat  = (|acc_wide[NUMBER_BITS+3:NUMBER_BITS]) ? {NUMBER_BITS{1'b1}}
                                                             : acc_wide[NUMBER_BITS-1:0];

    always_comb
    begin
        if (err_reg)
        begin
            eot_ok = 1'b0;
        end
        else if (term_reg)
        begin
            eot_ok = 1'b1;
        end
        else if (seq_reg)
        begin
            eot_ok = (kidx_reg == lcsp_pkg::SEQ_LEN);
        end
        else
        begin
            eot_ok = (phase_reg == PH_START) || (phase_reg == PH_AFTER_LEVEL);
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        kidx_next   = kidx_reg;
        level_next  = level_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        err_next    = err_reg;
        term_next   = term_reg;
        seq_next    = seq_reg;
        emit        = 1'b0;
        kind_next   = kind_reg;
        lvl_next    = lvl_reg;
        num_next    = num_reg;
        last_next   = last_reg;

        if (pop)
        begin
            if (q_entry.end_of_text)
            begin
                emit        = 1'b1;
                kind_next   = eot_ok ? lcsp_pkg::REC_OK : lcsp_pkg::REC_BAD;
                lvl_next    = lcsp_pkg::LVL_TASK;
                num_next    = '0;
                last_next   = 1'b0;
                phase_next  = PH_START;
                kidx_next   = 5'd0;
                level_next  = 1'b0;
                acc_next    = '0;
                digits_next = 1'b0;
                err_next    = 1'b0;
                term_next   = 1'b0;
                seq_next    = 1'b0;
            end
            else if (err_reg || term_reg)
            begin
                // ignored until end of text
            end
            else if (seq_reg)
            begin
                if (kidx_reg < lcsp_pkg::SEQ_LEN && c == lcsp_pkg::seq_char(kidx_reg))
                begin
                    kidx_next = kidx_inc;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else if (phase_reg != PH_IN_LEVEL)
            begin
                if (c == lcsp_pkg::CH_DOT && comma_ok)
                begin
                    term_next = 1'b1;
                end
                else if (c == lcsp_pkg::CH_COMMA && comma_ok)
                begin
                    phase_next = PH_AFTER_COMMA;
                end
                else if (c == lcsp_pkg::CH_UC_T || c == lcsp_pkg::CH_UC_L)
                begin
                    level_next = (c == lcsp_pkg::CH_UC_L);
                    kidx_next  = 5'd1;
                    phase_next = PH_IN_LEVEL;
                end
                else if (c == lcsp_pkg::CH_UC_S && phase_reg == PH_START)
                begin
                    seq_next  = 1'b1;
                    kidx_next = 5'd1;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else if (kidx_reg >= tmpl_len)
            begin
                err_next = 1'b1;
            end
            else if (!is_slot)
            begin
                if (c == tc)
                begin
                    kidx_next = kidx_inc;
                    if (kidx_inc == tmpl_len)
                    begin
                        phase_next = PH_AFTER_LEVEL;
                    end
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else if (q_entry.is_digit)
            begin
                acc_next    = acc_sat;
                digits_next = 1'b1;
            end
            else if (!digits_reg)
            begin
                err_next = 1'b1;
            end
            else
            begin
                // number ends on this character
                emit        = 1'b1;
                kind_next   = lcsp_pkg::REC_NUMBER;
                lvl_next    = is_list ? lcsp_pkg::LVL_ITER : {1'b0, level_reg};
                num_next    = acc_reg;
                last_next   = !(is_list && c == lcsp_pkg::CH_COMMA);
                acc_next    = '0;
                digits_next = 1'b0;
                if (!(is_list && c == lcsp_pkg::CH_COMMA))
                begin
                    kidx_next = kidx_inc;
                    if (kidx_inc < tmpl_len && c == tc_inc)
                    begin
                        kidx_next = kidx_inc + 5'd1;
                        if (kidx_inc + 5'd1 == tmpl_len)
                        begin
                            phase_next = PH_AFTER_LEVEL;
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
        end

        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (records.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            kidx_reg      <= 5'd0;
            level_reg     <= 1'b0;
            acc_reg       <= '0;
            digits_reg    <= 1'b0;
            err_reg       <= 1'b0;
            term_reg      <= 1'b0;
            seq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= lcsp_pkg::REC_NUMBER;
            lvl_reg       <= lcsp_pkg::LVL_TASK;
            num_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kidx_reg      <= kidx_next;
            level_reg     <= level_next;
            acc_reg       <= acc_next;
            digits_reg    <= digits_next;
            err_reg       <= err_next;
            term_reg      <= term_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            lvl_reg       <= lvl_next;
            num_reg       <= num_next;
            last_reg      <= last_next;
        end
    end

    assign records.valid         = out_valid_reg;
    assign records.record_kind   = kind_reg;
    assign records.level_kind    = lvl_reg;
    assign records.number_value  = num_reg;
    assign records.last_of_level = last_reg;
endmodule

// ===== src/loop_context_string_parser.sv =====
// Output path: a status request passes the queue and then the output register after
//   end_of_text is taken; a number does so after the character that ends it.
// Throughput: 1 character per cycle while the back-end output register is not stalled.
// Reset (rst_n low, async): queue empty, parser at start of text, no result pending.
module loop_context_string_parser #(
    parameter int NUMBER_BITS = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    lcsp_char_if.sink    chars,
    lcsp_rec_if.source   records
);
    // Front end: drops space, tab, newline and double quote, pre-decodes digits.
    // Characters dropped here change no parser state in any phase, so they never
    // reach the queue.
    logic               push;
    lcsp_pkg::q_entry_t push_entry;
    logic               q_ready;

    // Queue: two entries, lets the front keep taking characters while the
    // back end waits on a stalled output.
    logic               pop;
    logic               q_valid;
    lcsp_pkg::q_entry_t q_entry;

    lcsp_front u_front (
        .chars      (chars),
        .q_ready    (q_ready),
        .push       (push),
        .push_entry (push_entry)
    );

    lcsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // Back end: template matcher, decimal accumulator (shift-add times ten with
    // saturation), and the output register. Pops one entry per cycle whenever the
    // output register is empty or being drained.
    lcsp_back #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .records (records)
    );

`ifndef SYNTHESIS
    // status requests carry an all-zero payload
    a_status_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (records.valid && records.record_kind != lcsp_pkg::REC_NUMBER) |->
        (records.number_value == '0 && records.level_kind == lcsp_pkg::LVL_TASK &&
         !records.last_of_level))
        else $error("status request with nonzero payload");

    // record and level kinds stay within their codes
    a_kind_codes: assert property (@(posedge clk) disable iff (!rst_n)
        records.valid |->
        ((records.record_kind == lcsp_pkg::REC_NUMBER || records.record_kind == lcsp_pkg::REC_OK ||
          records.record_kind == lcsp_pkg::REC_BAD) &&
         (records.level_kind == lcsp_pkg::LVL_TASK || records.level_kind == lcsp_pkg::LVL_LOOP ||
          records.level_kind == lcsp_pkg::LVL_ITER)))
        else $error("undefined record or level kind");

    // blanks never enter the queue; end of text always does
    a_front_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.ready) |->
        (push == (chars.end_of_text ||
                  !(chars.char_code == lcsp_pkg::CH_SPACE || chars.char_code == lcsp_pkg::CH_TAB ||
                    chars.char_code == lcsp_pkg::CH_NL || chars.char_code == lcsp_pkg::CH_QUOTE))))
        else $error("front filter mismatch");

    // the back end never pops an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
`endif
endmodule
